// ===== rtl/vcd_pkg.sv =====
// ---------------------------------------------------------------------------
// vcd_pkg
// Shared types and constants for the cluster dissimilarity pipeline.
// ---------------------------------------------------------------------------
package vcd_pkg;

	localparam int COMPONENT_BITS = 32;
	localparam int FRAC_BITS      = 16;
	localparam int CFG_W          = 33;
	localparam int CFG_IDX_W      = 8;
	localparam int SCORE_W        = 18;
	localparam int QUO_BITS       = 18;          // quotient bits per ratio
	localparam int TERM_W         = QUO_BITS + 1;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_MAGNITUDE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE  = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(65536);
	localparam logic [TERM_W-1:0]  TERM_CAP  = TERM_W'(262144);   // 4.0
	localparam logic [TERM_W-1:0]  TERM_ONE  = TERM_W'(65536);    // 1.0
	localparam logic [TERM_W-1:0]  TERM_HALF = TERM_W'(32768);    // 0.5
	localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(196608);  // 3.0

	typedef struct packed {
		logic signed [COMPONENT_BITS-1:0] first_value_x;
		logic signed [COMPONENT_BITS-1:0] first_value_y;
		logic signed [COMPONENT_BITS-1:0] first_value_z;
		logic signed [COMPONENT_BITS-1:0] second_value_x;
		logic signed [COMPONENT_BITS-1:0] second_value_y;
		logic signed [COMPONENT_BITS-1:0] second_value_z;
		logic signed [COMPONENT_BITS-1:0] first_center_x;
		logic signed [COMPONENT_BITS-1:0] first_center_y;
		logic signed [COMPONENT_BITS-1:0] first_center_z;
		logic signed [COMPONENT_BITS-1:0] second_center_x;
		logic signed [COMPONENT_BITS-1:0] second_center_y;
		logic signed [COMPONENT_BITS-1:0] second_center_z;
	} vcd_req_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               zero_vector;
		logic               clipped;
	} vcd_rsp_t;

endpackage

// ===== rtl/vector_cluster_dissimilarity.sv =====
// ---------------------------------------------------------------------------
// vector_cluster_dissimilarity
// Dissimilarity score of a pair of clusters from value vectors and centroids.
// ---------------------------------------------------------------------------
// Fully pipelined: one request is taken every cycle unless the pipeline
// holds; its result passes 3 input/product/sum stages, 33 square root
// stages, 2 for magnitude difference and cosine numerator, 18 divider
// stages and the output register. Latency is set by the bit-per-stage
// square root and dividers. The whole pipeline holds while a result
// sits in the output register unread, so in_ready follows out_ready.
// Score = |m2-m1|/max_magnitude + (1-cos)/2 + |c1-c2|/max_distance in Q2.16,
// saturated at 3.0 (clipped). A zero value vector forces the direction term
// to 0.5 (zero_vector). A register written with 0 acts as 1 LSB.
// Configuration writes are always accepted; writes to unknown indexes are
// dropped.
module vector_cluster_dissimilarity (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  vcd_pkg::vcd_req_t              in_req,
	output logic                           out_valid,
	input  logic                           out_ready,
	output vcd_pkg::vcd_rsp_t              out_rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [vcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vcd_pkg::CFG_W-1:0]      cfg_data
);

	localparam int W     = vcd_pkg::COMPONENT_BITS;
	localparam int R     = W + 1;          // root width (distance needs one more bit)
	localparam int SW    = 2 * R;          // radicand width
	localparam int NW    = 2 * W + 2;      // cosine numerator / dot sums
	localparam int CW    = vcd_pkg::CFG_W;
	localparam int TW    = vcd_pkg::TERM_W;
	localparam int STEPS = vcd_pkg::QUO_BITS;

	// -----------------------------------------------------------------
	// configuration
	// -----------------------------------------------------------------
	logic [CW-1:0] max_magnitude_q, max_distance_q;
	logic [CW-1:0] mmag, mdist;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_magnitude_q <= vcd_pkg::CFG_RESET;
			max_distance_q  <= vcd_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				vcd_pkg::REG_MAX_MAGNITUDE: max_magnitude_q <= cfg_data;
				vcd_pkg::REG_MAX_DISTANCE:  max_distance_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as the smallest step
	assign mmag  = (max_magnitude_q == '0) ? CW'(1) : max_magnitude_q;
	assign mdist = (max_distance_q == '0) ? CW'(1) : max_distance_q;

	// -----------------------------------------------------------------
	// global advance: everything moves unless a result is held
	// -----------------------------------------------------------------
	logic en;
	logic out_valid_q;
	vcd_pkg::vcd_rsp_t out_rsp_q;

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	// -----------------------------------------------------------------
	// S1: magnitudes of components, centroid differences, zero check
	// -----------------------------------------------------------------
	logic signed [W-1:0] v1 [3], v2 [3], c1 [3], c2 [3];

	assign v1[0] = in_req.first_value_x;
	assign v1[1] = in_req.first_value_y;
	assign v1[2] = in_req.first_value_z;
	assign v2[0] = in_req.second_value_x;
	assign v2[1] = in_req.second_value_y;
	assign v2[2] = in_req.second_value_z;
	assign c1[0] = in_req.first_center_x;
	assign c1[1] = in_req.first_center_y;
	assign c1[2] = in_req.first_center_z;
	assign c2[0] = in_req.second_center_x;
	assign c2[1] = in_req.second_center_y;
	assign c2[2] = in_req.second_center_z;

	logic         vld_s1;
	logic [W-1:0] a1_s1 [3], a2_s1 [3];
	logic [R-1:0] ad_s1 [3];
	logic [2:0]   sgn_s1;
	logic         zero_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid;
	end

	for (genvar i = 0; i < 3; i++) begin : g_s1
		logic signed [R-1:0] dc;
		assign dc = R'(c1[i]) - R'(c2[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				a1_s1[i]  <= v1[i][W-1] ? (~v1[i] + W'(1)) : v1[i];
				a2_s1[i]  <= v2[i][W-1] ? (~v2[i] + W'(1)) : v2[i];
				ad_s1[i]  <= dc[R-1] ? (~dc + R'(1)) : dc;
				sgn_s1[i] <= v1[i][W-1] ^ v2[i][W-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= ((v1[0] == '0) && (v1[1] == '0) && (v1[2] == '0)) ||
			           ((v2[0] == '0) && (v2[1] == '0) && (v2[2] == '0));
		end
	end

	// -----------------------------------------------------------------
	// S2: squares and dot-product terms
	// -----------------------------------------------------------------
	logic            vld_s2, zero_s2;
	logic [2*W-1:0]  sq1_s2 [3], sq2_s2 [3], dp_s2 [3];
	logic [SW-1:0]   sqd_s2 [3];
	logic [2:0]      sgn_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	for (genvar i = 0; i < 3; i++) begin : g_s2
		always_ff @(posedge clk) begin
			if (en) begin
				sq1_s2[i] <= a1_s1[i] * a1_s1[i];
				sq2_s2[i] <= a2_s1[i] * a2_s1[i];
				dp_s2[i]  <= a1_s1[i] * a2_s1[i];
				sqd_s2[i] <= ad_s1[i] * ad_s1[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s2  <= sgn_s1;
			zero_s2 <= zero_s1;
		end
	end

	// -----------------------------------------------------------------
	// S3 (root stage 0): square sums, split dot product
	// Lanes: 0 = first value, 1 = second value, 2 = centroid distance.
	// -----------------------------------------------------------------
	logic          sq_vld_s  [0:R];
	logic          sq_zero_s [0:R];
	logic [NW-1:0] sq_pos_s  [0:R];
	logic [NW-1:0] sq_neg_s  [0:R];
	logic [SW-1:0] sq_rad_s  [0:R][0:2];
	logic [R:0]    sq_rem_s  [0:R][0:2];
	logic [R-1:0]  sq_root_s [0:R][0:2];

	logic [NW-1:0] pos_sum, neg_sum;

	always_comb begin
		pos_sum = '0;
		neg_sum = '0;
		for (int i = 0; i < 3; i++) begin
			if (sgn_s2[i]) neg_sum = neg_sum + NW'(dp_s2[i]);
			else           pos_sum = pos_sum + NW'(dp_s2[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_vld_s[0] <= 1'b0;
		else if (en) sq_vld_s[0] <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rad_s[0][0] <= SW'(sq1_s2[0]) + SW'(sq1_s2[1]) + SW'(sq1_s2[2]);
			sq_rad_s[0][1] <= SW'(sq2_s2[0]) + SW'(sq2_s2[1]) + SW'(sq2_s2[2]);
			sq_rad_s[0][2] <= sqd_s2[0] + sqd_s2[1] + sqd_s2[2];
			for (int l = 0; l < 3; l++) begin
				sq_rem_s[0][l]  <= '0;
				sq_root_s[0][l] <= '0;
			end
			sq_pos_s[0]  <= pos_sum;
			sq_neg_s[0]  <= neg_sum;
			sq_zero_s[0] <= zero_s2;
		end
	end

	// -----------------------------------------------------------------
	// square root: one root bit per stage, two radicand bits consumed
	// -----------------------------------------------------------------
	for (genvar k = 0; k < R; k++) begin : g_root
		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [R+2:0] cur, trial;
			logic         ge;

			assign cur   = {sq_rem_s[k][l], sq_rad_s[k][l][SW-1 -: 2]};
			assign trial = {1'b0, sq_root_s[k][l], 2'b01};
			assign ge    = cur >= trial;

			always_ff @(posedge clk) begin
				if (en) begin
					sq_rad_s[k+1][l]  <= sq_rad_s[k][l] << 2;
					sq_rem_s[k+1][l]  <= ge ? (R+1)'(cur - trial) : (R+1)'(cur);
					sq_root_s[k+1][l] <= {sq_root_s[k][l][R-2:0], ge};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_vld_s[k+1] <= 1'b0;
			else if (en) sq_vld_s[k+1] <= sq_vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_pos_s[k+1]  <= sq_pos_s[k];
				sq_neg_s[k+1]  <= sq_neg_s[k];
				sq_zero_s[k+1] <= sq_zero_s[k];
			end
		end
	end

	// -----------------------------------------------------------------
	// S4: magnitude difference and |v1||v2|
	// -----------------------------------------------------------------
	logic           vld_s4, zero_s4;
	logic [W-1:0]   m1, m2;
	logic [W-1:0]   dm_s4;
	logic [R-1:0]   dist_s4;
	logic [2*W-1:0] mm_s4;
	logic [NW-1:0]  pos_s4, neg_s4;

	assign m1 = sq_root_s[R][0][W-1:0];
	assign m2 = sq_root_s[R][1][W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= sq_vld_s[R];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dm_s4   <= (m2 > m1) ? (m2 - m1) : (m1 - m2);
			mm_s4   <= m1 * m2;
			dist_s4 <= sq_root_s[R][2];
			pos_s4  <= sq_pos_s[R];
			neg_s4  <= sq_neg_s[R];
			zero_s4 <= sq_zero_s[R];
		end
	end

	// -----------------------------------------------------------------
	// S5: cosine numerator m1*m2 - dot (floored at 0), denominator 2*m1*m2
	// -----------------------------------------------------------------
	logic            vld_s5, zero_s5;
	logic [W-1:0]    dm_s5;
	logic [R-1:0]    dist_s5;
	logic [NW-1:0]   num_s5;
	logic [2*W:0]    den_s5;
	logic [NW-1:0]   mm_neg;

	assign mm_neg = NW'(mm_s4) + neg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s5  <= (mm_neg > pos_s4) ? (mm_neg - pos_s4) : '0;
			den_s5  <= {mm_s4, 1'b0};
			dm_s5   <= dm_s4;
			dist_s5 <= dist_s4;
			zero_s5 <= zero_s4;
		end
	end

	// -----------------------------------------------------------------
	// ratio dividers, all three in lockstep
	// -----------------------------------------------------------------
	logic [TW-1:0] t1_q, t2_q, t3_q;

	vcd_div #(.NUM_W(W), .DEN_W(CW)) u_div_mag (
		.clk (clk),
		.en  (en),
		.num (dm_s5),
		.den (mmag),
		.quo (t1_q)
	);

	vcd_div #(.NUM_W(NW), .DEN_W(2 * W + 1)) u_div_dir (
		.clk (clk),
		.en  (en),
		.num (num_s5),
		.den (den_s5),
		.quo (t2_q)
	);

	vcd_div #(.NUM_W(R), .DEN_W(CW)) u_div_dist (
		.clk (clk),
		.en  (en),
		.num (dist_s5),
		.den (mdist),
		.quo (t3_q)
	);

	logic dv_vld_s  [1:STEPS];
	logic dv_zero_s [1:STEPS];

	for (genvar j = 1; j <= STEPS; j++) begin : g_dv
		logic vin, zin;
		if (j == 1) begin : g_first
			assign vin = vld_s5;
			assign zin = zero_s5;
		end else begin : g_next
			assign vin = dv_vld_s[j-1];
			assign zin = dv_zero_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld_s[j] <= 1'b0;
			else if (en) dv_vld_s[j] <= vin;
		end

		always_ff @(posedge clk) begin
			if (en) dv_zero_s[j] <= zin;
		end
	end

	// -----------------------------------------------------------------
	// output: direction term fixup, sum, saturation
	// -----------------------------------------------------------------
	logic [TW-1:0] t2;
	logic [TW+1:0] sum;
	logic          clip;

	assign t2   = dv_zero_s[STEPS] ? vcd_pkg::TERM_HALF :
	              ((t2_q > vcd_pkg::TERM_ONE) ? vcd_pkg::TERM_ONE : t2_q);
	assign sum  = (TW+2)'(t1_q) + (TW+2)'(t2) + (TW+2)'(t3_q);
	assign clip = sum > (TW+2)'(vcd_pkg::SCORE_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= dv_vld_s[STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rsp_q.score       <= clip ? vcd_pkg::SCORE_MAX : sum[vcd_pkg::SCORE_W-1:0];
			out_rsp_q.zero_vector <= dv_zero_s[STEPS];
			out_rsp_q.clipped     <= clip;
		end
	end

	// -----------------------------------------------------------------
	// assertions
	// -----------------------------------------------------------------
	a_clip_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_rsp.clipped |-> out_rsp.score == vcd_pkg::SCORE_MAX)
		else $error("clipped result not saturated");

	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_rsp.score <= vcd_pkg::SCORE_MAX)
		else $error("score above 3.0");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("pipeline held without a pending result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_rsp))
		else $error("held result changed");

endmodule

// ===== rtl/vcd_div.sv =====
// ---------------------------------------------------------------------------
// vcd_div
// Pipelined restoring divider: floor(num * 2^16 / den), held at 4.0.
// One quotient bit per stage, QUO_BITS stages, advances on en.
// ---------------------------------------------------------------------------
module vcd_div #(
	parameter int NUM_W = 66,
	parameter int DEN_W = 65
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic [NUM_W-1:0]                num,
	input  logic [DEN_W-1:0]                den,
	output logic [vcd_pkg::TERM_W-1:0]      quo
);

	localparam int STEPS = vcd_pkg::QUO_BITS;
	localparam int RW    = ((NUM_W > DEN_W + 2) ? NUM_W : DEN_W + 2) + 1;

	logic [RW-1:0]    rem_s [1:STEPS];
	logic [DEN_W-1:0] den_s [1:STEPS];
	logic [STEPS-1:0] q_s   [1:STEPS];
	logic             cap_s [1:STEPS];

	logic cap_in;
	// at 4.0 or more the quotient is pinned
	assign cap_in = RW'(num) >= (RW'(den) << 2);

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		logic [RW-1:0]    rem_in, shifted, dv;
		logic [DEN_W-1:0] den_in;
		logic [STEPS-1:0] q_in;
		logic             cap_pass;
		logic             ge;

		if (j == 0) begin : g_first
			assign rem_in   = RW'(num);
			assign den_in   = den;
			assign q_in     = '0;
			assign cap_pass = cap_in;
		end else begin : g_next
			assign rem_in   = rem_s[j];
			assign den_in   = den_s[j];
			assign q_in     = q_s[j];
			assign cap_pass = cap_s[j];
		end

		// first two steps give the integer bits, then shift in fraction bits
		assign shifted = (j < 2) ? rem_in : (rem_in << 1);
		assign dv      = (j == 0) ? (RW'(den_in) << 1) : RW'(den_in);
		assign ge      = shifted >= dv;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? (shifted - dv) : shifted;
				den_s[j+1] <= den_in;
				q_s[j+1]   <= {q_in[STEPS-2:0], ge};
				cap_s[j+1] <= cap_pass;
			end
		end
	end

	assign quo = cap_s[STEPS] ? vcd_pkg::TERM_CAP : {1'b0, q_s[STEPS]};

endmodule

// ===== dv/vector_cluster_dissimilarity_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// vector_cluster_dissimilarity_tb
// Streams cluster pairs through the dissimilarity pipeline and checks every
// score and flag against an exact integer prediction made at acceptance.
// ---------------------------------------------------------------------------
module vector_cluster_dissimilarity_tb;

	localparam int    LATENCY     = 57;
	localparam int    N_RANDOM    = 1200;
	localparam longint CYCLE_LIMIT = 400000;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	vcd_pkg::vcd_req_t             in_req;
	logic                          out_valid;
	logic                          out_ready;
	vcd_pkg::vcd_rsp_t             out_rsp;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [vcd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [vcd_pkg::CFG_W-1:0]     cfg_data;

	// testbench copy of the two normalizing registers
	logic [vcd_pkg::CFG_W-1:0] mag_limit;
	logic [vcd_pkg::CFG_W-1:0] dist_limit;

	vcd_pkg::vcd_req_t pending_reqs[$];   // requests waiting for the driver
	vcd_pkg::vcd_rsp_t expected_scores[$];
	int       errors;
	longint   cycles;
	logic     send_en;           // driver may launch requests
	int       burst_left;
	int       gap_left;
	int       stall_mode;

	vector_cluster_dissimilarity u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
		.out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---- predictor ------------------------------------------------------
	function automatic logic [63:0] isqrt128(logic [127:0] s);
		logic [63:0]  r;
		logic [63:0]  c;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			c = r | (64'd1 << i);
			if ({64'd0, c} * {64'd0, c} <= s)
				r = c;
		end
		return r;
	endfunction

	// floor(a*65536/b), held at 4.0
	function automatic logic [18:0] q16_ratio(logic [127:0] a, logic [127:0] b);
		logic [143:0] q;
		q = {a, 16'd0} / {16'd0, b};
		return (q >= 144'd262144) ? 19'd262144 : q[18:0];
	endfunction

	function automatic logic [127:0] sq_sum(logic signed [63:0] a,
			logic signed [63:0] b, logic signed [63:0] c);
		logic signed [127:0] t;
		t = 128'(a) * 128'(a) + 128'(b) * 128'(b) + 128'(c) * 128'(c);
		return t;
	endfunction

	function automatic vcd_pkg::vcd_rsp_t dissimilarity(vcd_pkg::vcd_req_t r);
		logic [63:0]         m1, m2, dm, c_dist, mmag, mdist;
		logic signed [127:0] dotp, num;
		logic [127:0]        mm;
		logic [18:0]         t1, t2, t3;
		logic [20:0]         total;
		vcd_pkg::vcd_rsp_t   res;
		mmag  = (mag_limit == 0) ? 64'd1 : 64'(mag_limit);
		mdist = (dist_limit == 0) ? 64'd1 : 64'(dist_limit);
		m1 = isqrt128(sq_sum(r.first_value_x, r.first_value_y, r.first_value_z));
		m2 = isqrt128(sq_sum(r.second_value_x, r.second_value_y, r.second_value_z));
		dm = (m2 > m1) ? m2 - m1 : m1 - m2;
		t1 = q16_ratio(128'(dm), 128'(mmag));
		res.zero_vector = (m1 == 0 || m2 == 0);
		if (res.zero_vector) begin
			t2 = vcd_pkg::TERM_HALF;
		end else begin
			dotp = 128'(r.first_value_x) * 128'(r.second_value_x)
				+ 128'(r.first_value_y) * 128'(r.second_value_y)
				+ 128'(r.first_value_z) * 128'(r.second_value_z);
			mm  = 128'(m1) * 128'(m2);
			num = $signed(mm) - dotp;
			if (num < 0)
				num = 0;
			t2 = q16_ratio(num, mm << 1);
			if (t2 > vcd_pkg::TERM_ONE)
				t2 = vcd_pkg::TERM_ONE;
		end
		c_dist = isqrt128(sq_sum(
			64'(r.first_center_x) - 64'(r.second_center_x),
			64'(r.first_center_y) - 64'(r.second_center_y),
			64'(r.first_center_z) - 64'(r.second_center_z)));
		t3 = q16_ratio(128'(c_dist), 128'(mdist));
		total = t1 + t2 + t3;
		res.clipped = (total > vcd_pkg::SCORE_MAX);
		res.score = res.clipped ? vcd_pkg::SCORE_MAX : total[17:0];
		return res;
	endfunction

	// ---- stimulus helpers ----------------------------------------------
	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			2: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
			3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			4: return '0;
			default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
		endcase
	endfunction

	function automatic vcd_pkg::vcd_req_t rand_req();
		vcd_pkg::vcd_req_t r;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r.first_value_x   = rand_comp();
		r.first_value_y   = rand_comp();
		r.first_value_z   = rand_comp();
		r.second_value_x  = rand_comp();
		r.second_value_y  = rand_comp();
		r.second_value_z  = rand_comp();
		r.first_center_x  = rand_comp();
		r.first_center_y  = rand_comp();
		r.first_center_z  = rand_comp();
		case ($urandom_range(0, 3))
			0: begin // near-parallel or anti-parallel vectors
				r.second_value_x = r.first_value_x + 32'($urandom_range(0, 7));
				r.second_value_y = r.first_value_y;
				r.second_value_z = r.first_value_z;
				if ($urandom_range(0, 1)) begin
					r.second_value_x = -r.first_value_x;
					r.second_value_y = -r.first_value_y;
					r.second_value_z = -r.first_value_z;
				end
			end
			1: begin // nearby centroids
				r.second_center_x = r.first_center_x + 32'($urandom_range(0, 65536));
				r.second_center_y = r.first_center_y - 32'($urandom_range(0, 65536));
				r.second_center_z = r.first_center_z;
			end
			default: begin
				r.second_center_x = rand_comp();
				r.second_center_y = rand_comp();
				r.second_center_z = rand_comp();
			end
		endcase
		return r;
	endfunction

	function automatic vcd_pkg::vcd_req_t uniform_req(logic [31:0] v);
		vcd_pkg::vcd_req_t r;
		r = {12{v}};
		return r;
	endfunction

	task automatic write_reg(logic [vcd_pkg::CFG_IDX_W-1:0] idx,
			logic [vcd_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		// mirror only the registers the block knows
		if (idx == vcd_pkg::REG_MAX_MAGNITUDE)
			mag_limit = val;
		else if (idx == vcd_pkg::REG_MAX_DISTANCE)
			dist_limit = val;
	endtask

	// wait for the pipeline to drain before touching registers
	task automatic drain();
		wait (pending_reqs.size() == 0 && !in_valid);
		wait (expected_scores.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic push_random(int n);
		for (int i = 0; i < n; i++)
			pending_reqs.push_back(rand_req());
	endtask

	// ---- driver: bursts with random gaps -------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_req     <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_scores.push_back(dissimilarity(in_req));
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (send_en && pending_reqs.size() > 0) begin
					in_req   <= pending_reqs.pop_front();
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---- monitor and receiver stall pattern ----------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_mode <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_scores.size() == 0) begin
					$display("%0t: unexpected result score=%0d zero=%0b clip=%0b",
						$time, out_rsp.score, out_rsp.zero_vector, out_rsp.clipped);
					errors++;
				end else begin
					vcd_pkg::vcd_rsp_t exp_rsp;
					exp_rsp = expected_scores.pop_front();
					if (out_rsp.score !== exp_rsp.score) begin
						$display("%0t: score expected %0d actual %0d",
							$time, exp_rsp.score, out_rsp.score);
						errors++;
					end
					if (out_rsp.zero_vector !== exp_rsp.zero_vector) begin
						$display("%0t: zero_vector expected %0b actual %0b",
							$time, exp_rsp.zero_vector, out_rsp.zero_vector);
						errors++;
					end
					if (out_rsp.clipped !== exp_rsp.clipped) begin
						$display("%0t: clipped expected %0b actual %0b",
							$time, exp_rsp.clipped, out_rsp.clipped);
						errors++;
					end
				end
			end
			// pattern: always ready, periodic stalls, random, slow
			if ($urandom_range(0, 199) == 0)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= (cycles % 3) != 0;
				2: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// ---- watchdog -------------------------------------------------------
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---- sequence -------------------------------------------------------
	initial begin
		vcd_pkg::vcd_req_t r;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		send_en    = 1'b0;
		errors     = 0;
		cycles     = 0;
		mag_limit  = vcd_pkg::CFG_RESET;
		dist_limit = vcd_pkg::CFG_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, zero vectors, parallel/opposite, clipping
		pending_reqs.push_back(uniform_req(32'h0));
		pending_reqs.push_back(uniform_req(32'h7FFF_FFFF));
		pending_reqs.push_back(uniform_req(32'h8000_0000));
		pending_reqs.push_back(uniform_req(32'hFFFF_FFFF));
		pending_reqs.push_back(uniform_req(32'h0001_0000));
		r = uniform_req(32'h0001_0000);
		r.first_value_x = 32'hFFFF_0000; r.first_value_y = 32'hFFFF_0000;
		r.first_value_z = 32'hFFFF_0000;   // opposite directions
		pending_reqs.push_back(r);
		r = '0;
		r.first_value_x = 32'h0001_0000; r.second_value_y = 32'h0003_0000;
		pending_reqs.push_back(r);          // orthogonal
		r = '0;
		r.second_value_z = 32'h0002_0000;   // first vector zero
		pending_reqs.push_back(r);
		r = '0;
		r.first_value_y = 32'h8000_0000;    // second vector zero
		r.first_center_x = 32'h7FFF_FFFF; r.second_center_x = 32'h8000_0000;
		pending_reqs.push_back(r);
		r = uniform_req(32'h8000_0000);
		r.second_value_x = 32'h7FFF_FFFF; r.second_value_y = 32'h7FFF_FFFF;
		r.second_value_z = 32'h7FFF_FFFF;
		r.second_center_x = 32'h7FFF_FFFF; r.second_center_y = 32'h7FFF_FFFF;
		r.second_center_z = 32'h7FFF_FFFF;
		pending_reqs.push_back(r);
		r = '0;
		r.first_value_x = 32'h0000_8000; r.second_value_x = 32'h0000_C000;
		r.first_center_x = 32'h0000_4000;
		pending_reqs.push_back(r);          // small sum, no clipping
		push_random(8);
		send_en = 1'b1;
		drain();

		// extreme register values, plus writes to unknown indexes
		write_reg(vcd_pkg::REG_MAX_MAGNITUDE, '0);
		write_reg(vcd_pkg::REG_MAX_DISTANCE, {vcd_pkg::CFG_W{1'b1}});
		write_reg(vcd_pkg::CFG_IDX_W'(2), vcd_pkg::CFG_W'(12345));
		write_reg(vcd_pkg::CFG_IDX_W'(255), '0);
		push_random(300);
		drain();

		write_reg(vcd_pkg::REG_MAX_MAGNITUDE, {vcd_pkg::CFG_W{1'b1}});
		write_reg(vcd_pkg::REG_MAX_DISTANCE, '0);
		push_random(300);
		drain();

		// sender holds off entirely while the pipeline empties
		write_reg(vcd_pkg::REG_MAX_MAGNITUDE, vcd_pkg::CFG_W'(64'h0_8000_0000));
		write_reg(vcd_pkg::REG_MAX_DISTANCE, vcd_pkg::CFG_W'(64'h1_0000_0000));
		push_random(150);
		wait (pending_reqs.size() == 0 && !in_valid);
		send_en = 1'b0;
		push_random(150);
		wait (expected_scores.size() == 0);
		send_en = 1'b1;
		drain();

		write_reg(vcd_pkg::REG_MAX_MAGNITUDE,
			vcd_pkg::CFG_W'($urandom_range(1, 32'hFFFF_FFFF)));
		write_reg(vcd_pkg::REG_MAX_DISTANCE,
			vcd_pkg::CFG_W'($urandom_range(1, 32'hFFFF_FFFF)));
		push_random(300);
		drain();

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/vcd_pkg.sv
rtl/vcd_div.sv
rtl/vector_cluster_dissimilarity.sv
dv/vector_cluster_dissimilarity_tb.sv
